// ----- src/adcps_pkg.sv -----
package adcps_pkg;

  // Widths of the millivolt and millibar quantities.
  localparam int unsigned MV_W   = 13;
  localparam int unsigned MBAR_W = 16;

  // Configuration port geometry.
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned REG_IDX_W = 2;

  // Register indexes (byte address divided by four).
  localparam logic [REG_IDX_W-1:0] REG_FS_MV   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FS_MBAR = 2'd2;

  // Reference voltage and the allowed full-scale voltage range.
  localparam logic [MV_W-1:0] REF_MV    = 13'd5000;
  localparam logic [MV_W-1:0] FS_MV_MIN = 13'd5;
  localparam logic [MV_W-1:0] FS_MV_MAX = 13'd5000;

  // Register reset values.
  localparam logic [MV_W-1:0]   FS_MV_RST   = 13'd5000;
  localparam logic [MV_W-1:0]   OFFSET_RST  = 13'd0;
  localparam logic [MBAR_W-1:0] FS_MBAR_RST = 16'd10000;

endpackage

// ----- src/adcps_div.sv -----
module adcps_div #(
  parameter int unsigned D_W = 13,
  parameter int unsigned Q_W = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [D_W+Q_W-1:0] num_i,
  input  logic [D_W-1:0]     den_i,
  output logic               valid_o,
  output logic [Q_W-1:0]     quo_o
);

  // Restoring division, one quotient bit per stage. The numerator must be
  // below den_i * 2**Q_W, so its upper D_W bits form a partial remainder
  // that is already smaller than the divisor.

  logic [D_W-1:0] rem_in [Q_W];
  logic [Q_W-1:0] low_in [Q_W];
  logic [D_W-1:0] den_in [Q_W];
  logic           vld_in [Q_W];

  logic [D_W-1:0] rem_d [Q_W];
  logic [Q_W-1:0] low_d [Q_W];

  logic [D_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0] low_q [Q_W];
  logic [D_W-1:0] den_q [Q_W];
  logic           vld_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [D_W:0] trial;
    logic [D_W:0] diff;
    logic         ge;

    if (k == 0) begin : g_first
      assign rem_in[k] = num_i[D_W+Q_W-1:Q_W];
      assign low_in[k] = num_i[Q_W-1:0];
      assign den_in[k] = den_i;
      assign vld_in[k] = valid_i;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign low_in[k] = low_q[k-1];
      assign den_in[k] = den_q[k-1];
      assign vld_in[k] = vld_q[k-1];
    end

    assign trial = {rem_in[k], low_in[k][Q_W-1]};
    assign diff  = trial - {1'b0, den_in[k]};
    assign ge    = (trial >= {1'b0, den_in[k]});

    // Quotient bits shift in at the bottom as numerator bits leave the top.
    assign rem_d[k] = ge ? diff[D_W-1:0] : trial[D_W-1:0];
    assign low_d[k] = {low_in[k][Q_W-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d[k];
      low_q[k] <= low_d[k];
      den_q[k] <= den_in[k];
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quo_o   = low_q[Q_W-1];

  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (num_i[D_W+Q_W-1:Q_W] < den_i))
    else $error("numerator too large for the quotient width");

  a_rem_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Q_W-1] |-> (rem_q[Q_W-1] < den_q[Q_W-1]))
    else $error("final remainder not below divisor");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> ##(Q_W-1) vld_q[Q_W-1])
    else $error("valid bit lost in divider pipeline");

endmodule

// ----- src/adc_to_pressure_scaler_unit.sv -----
// ADC-to-pressure scaler. Each request carries one raw ADC sample and
// yields one pressure in millibar. The block accepts a request in every
// clock cycle (busy stays low) and presents each result on
// pressure_millibar_o for one cycle with done_o high. Each request passes
// through two pipelined restoring dividers that resolve one quotient bit per
// stage (13 and 16 stages) plus seven stages for the multiplies, clamps and
// the output register, whatever ADC_BITS is.
// Results cannot be held off, so they must be captured when done_o is high.
// Registers at byte 0x0 (full-scale mV), 0x4 (offset mV) and 0x8
// (full-scale mbar) should be written only while no request is in flight.
module adc_to_pressure_scaler_unit #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ADC_BITS-1:0]        adc_sample_i,
  output logic                       done_o,
  output logic [adcps_pkg::MBAR_W-1:0] pressure_millibar_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [adcps_pkg::APB_AW-1:0] paddr,
  input  logic [adcps_pkg::APB_DW-1:0] pwdata,
  output logic [adcps_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  import adcps_pkg::*;

  localparam int unsigned PROD_W = ADC_BITS + MV_W;
  localparam int unsigned LAT    = MV_W + MBAR_W + 7;
  localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};

  // Configuration registers.
  logic [MV_W-1:0]      fs_mv_q;
  logic [MV_W-1:0]      offset_q;
  logic [MBAR_W-1:0]    fs_mbar_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_mv_q   <= FS_MV_RST;
      offset_q  <= OFFSET_RST;
      fs_mbar_q <= FS_MBAR_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FS_MV:   fs_mv_q   <= pwdata[MV_W-1:0];
        REG_OFFSET:  offset_q  <= pwdata[MV_W-1:0];
        REG_FS_MBAR: fs_mbar_q <= pwdata[MBAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FS_MV:   prdata = APB_DW'(fs_mv_q);
      REG_OFFSET:  prdata = APB_DW'(offset_q);
      REG_FS_MBAR: prdata = APB_DW'(fs_mbar_q);
      default:     prdata = '0;
    endcase
  end

  // Saturated full scale; users keep it stable while requests fly, unenforced.
  logic [MV_W-1:0] fs_mv;
  assign fs_mv = (fs_mv_q < FS_MV_MIN) ? FS_MV_MIN :
                 (fs_mv_q > FS_MV_MAX) ? FS_MV_MAX : fs_mv_q;

  // Stage 0: capture the sample and form ADC_MAX * full scale.
  logic                v0_q;
  logic [ADC_BITS-1:0] smp0_q;
  logic [PROD_W-1:0]   num0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    smp0_q <= adc_sample_i;
    num0_q <= PROD_W'(ADC_MAX) * PROD_W'(fs_mv);
  end

  // Full-scale count = ADC_MAX * full scale / reference voltage. Multiplying by
  // the rounded-up reciprocal of the reference and dropping RCP_SHIFT bits is
  // exact for every PROD_W-bit numerator, since the rounding error of the
  // reciprocal times the reference stays below 2**MV_W.
  localparam int unsigned     RCP_SHIFT = PROD_W + MV_W;
  localparam int unsigned     CPROD_W   = RCP_SHIFT + ADC_BITS;
  localparam longint unsigned RECIP     =
    ((64'd1 << RCP_SHIFT) + 64'(REF_MV) - 64'd1) / 64'(REF_MV);

  logic                vc_q;
  logic [ADC_BITS-1:0] fcnt_raw_q;
  logic [ADC_BITS-1:0] smpc_q;
  logic [CPROD_W-1:0]  cprod;

  assign cprod = CPROD_W'(num0_q) * CPROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fcnt_raw_q <= cprod[CPROD_W-1:RCP_SHIFT];
    smpc_q     <= smp0_q;
  end

  // Stage 1: force the count to at least one and clamp the sample to it.
  logic                v1_q;
  logic [ADC_BITS-1:0] fcnt1_q;
  logic [ADC_BITS-1:0] smp1_q;
  logic [ADC_BITS-1:0] fcnt;

  assign fcnt = (fcnt_raw_q == '0) ? ADC_BITS'(1) : fcnt_raw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fcnt1_q <= fcnt;
    smp1_q  <= (smpc_q > fcnt) ? fcnt : smpc_q;
  end

  // Stage 2: full scale * clamped sample.
  logic                v2_q;
  logic [ADC_BITS-1:0] fcnt2_q;
  logic [PROD_W-1:0]   prod2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fcnt2_q <= fcnt1_q;
    prod2_q <= PROD_W'(fs_mv) * PROD_W'(smp1_q);
  end

  // Sample in millivolts; never above full scale since the sample was clamped.
  logic            v3_div;
  logic [MV_W-1:0] mv_raw;

  adcps_div #(
    .D_W (ADC_BITS),
    .Q_W (MV_W)
  ) u_div_mv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .num_i   (prod2_q),
    .den_i   (fcnt2_q),
    .valid_o (v3_div),
    .quo_o   (mv_raw)
  );

  // Stage 3: remove the sensor offset, floored at zero.
  logic            v3_q;
  logic [MV_W-1:0] mv3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v3_div;
    end
  end

  always_ff @(posedge clk_i) begin
    mv3_q <= (mv_raw > offset_q) ? (mv_raw - offset_q) : '0;
  end

  // Stage 4: full-scale millibar * millivolts.
  localparam int unsigned PROD4_W = MBAR_W + MV_W;

  logic               v4_q;
  logic [PROD4_W-1:0] prod4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod4_q <= PROD4_W'(fs_mbar_q) * PROD4_W'(mv3_q);
  end

  logic              v5_div;
  logic [MBAR_W-1:0] mbar_raw;

  adcps_div #(
    .D_W (MV_W),
    .Q_W (MBAR_W)
  ) u_div_mbar (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .num_i   (prod4_q),
    .den_i   (fs_mv),
    .valid_o (v5_div),
    .quo_o   (mbar_raw)
  );

  // Output register.
  logic              done_q;
  logic [MBAR_W-1:0] pressure_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v5_div;
    end
  end

  always_ff @(posedge clk_i) begin
    pressure_q <= mbar_raw;
  end

  assign done_o              = done_q;
  assign pressure_millibar_o = pressure_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("request produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##LAT !done_o)
    else $error("result without a request");

  a_mv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_div |-> (mv_raw <= fs_mv))
    else $error("millivolt value above full scale");

  a_mbar_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pressure_millibar_o <= fs_mbar_q))
    else $error("pressure above full-scale millibar");

endmodule

// ----- dv/adc_pressure_checker.sv -----
`timescale 1ns / 100ps

module adc_pressure_checker #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [ADC_BITS-1:0]           adc_sample_i,
  input  logic                          done_i,
  input  logic [adcps_pkg::MBAR_W-1:0]  pressure_millibar_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [adcps_pkg::APB_AW-1:0]  paddr_i,
  input  logic [adcps_pkg::APB_DW-1:0]  pwdata_i,
  input  logic [adcps_pkg::APB_DW-1:0]  prdata_i,
  input  logic                          pready_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import adcps_pkg::*;

  logic [MV_W-1:0]   fs_mv_q;
  logic [MV_W-1:0]   offset_mv_q;
  logic [MBAR_W-1:0] fs_mbar_q;
  logic [MBAR_W-1:0] pressure_due_q[$];

  function automatic logic [MBAR_W-1:0] scale_pressure(input logic [ADC_BITS-1:0] sample,
                                                       input logic [MV_W-1:0] fs_mv_raw,
                                                       input logic [MV_W-1:0] offset_mv,
                                                       input logic [MBAR_W-1:0] fs_mbar);
    longint unsigned adc_max;
    longint unsigned fs_mv;
    longint unsigned full_count;
    longint unsigned clamped;
    longint unsigned mv;
    longint unsigned mbar;
    adc_max = (64'd1 << ADC_BITS) - 1;
    fs_mv = fs_mv_raw;
    if (fs_mv < FS_MV_MIN) fs_mv = FS_MV_MIN;
    if (fs_mv > FS_MV_MAX) fs_mv = FS_MV_MAX;
    full_count = adc_max * fs_mv / REF_MV;
    if (full_count == 0) full_count = 1;
    clamped = sample;
    if (clamped > full_count) clamped = full_count;
    mv = fs_mv * clamped / full_count;
    if (mv > offset_mv) mv = mv - offset_mv;
    else mv = 0;
    mbar = fs_mbar * mv / fs_mv;
    return mbar[MBAR_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [REG_IDX_W-1:0] idx;
    logic [APB_DW-1:0]    reg_value;
    logic [MBAR_W-1:0]    due;
    if (!rst_ni) begin
      fs_mv_q      = FS_MV_RST;
      offset_mv_q  = OFFSET_RST;
      fs_mbar_q    = FS_MBAR_RST;
      fail_count_o = 0;
      pending_o    = 0;
      pressure_due_q.delete();
    end else begin
      idx = paddr_i[REG_IDX_W+1:2];
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (idx)
            REG_FS_MV:   fs_mv_q = pwdata_i[MV_W-1:0];
            REG_OFFSET:  offset_mv_q = pwdata_i[MV_W-1:0];
            REG_FS_MBAR: fs_mbar_q = pwdata_i[MBAR_W-1:0];
            default: ;
          endcase
        end else if (idx inside {REG_FS_MV, REG_OFFSET, REG_FS_MBAR}) begin
          case (idx)
            REG_FS_MV:  reg_value = APB_DW'(fs_mv_q);
            REG_OFFSET: reg_value = APB_DW'(offset_mv_q);
            default:    reg_value = APB_DW'(fs_mbar_q);
          endcase
          if (prdata_i !== reg_value) begin
            $error("prdata mismatch for register %0d: expected %0h, actual %0h",
                   idx, reg_value, prdata_i);
            fail_count_o++;
          end
        end
      end

      if (start_i && !busy_i) begin
        pressure_due_q.push_back(scale_pressure(adc_sample_i, fs_mv_q, offset_mv_q,
                                                fs_mbar_q));
        pending_o++;
      end

      if (done_i === 1'b1) begin
        if (pressure_due_q.size() == 0) begin
          $error("pressure_millibar: expected no result, actual %0d", pressure_millibar_i);
          fail_count_o++;
        end else begin
          due = pressure_due_q.pop_front();
          pending_o--;
          if (pressure_millibar_i !== due) begin
            $error("pressure_millibar mismatch: expected %0d, actual %0d",
                   due, pressure_millibar_i);
            fail_count_o++;
          end
        end
      end else if (done_i !== 1'b0) begin
        $error("done_o unknown: expected 0 or 1, actual %b", done_i);
        fail_count_o++;
      end
    end
  end

endmodule

// ----- dv/tb_adc_to_pressure_scaler_unit.sv -----
`timescale 1ns / 100ps

module tb_adc_to_pressure_scaler_unit;
  import adcps_pkg::*;

  localparam int unsigned ADC_BITS = 10;
  localparam int unsigned ADC_MAX = (1 << ADC_BITS) - 1;
  localparam int unsigned LATENCY = 36;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned PHASES = 9;
  localparam int unsigned PHASE_ITEMS = 50;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [ADC_BITS-1:0]   adc_sample;
  logic                  done;
  logic [MBAR_W-1:0]     pressure_millibar;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;

  // Current settings, kept only to aim samples at the interesting points.
  int unsigned fs_mv_set;
  int unsigned offset_set;
  int unsigned full_count;

  adc_to_pressure_scaler_unit #(
    .ADC_BITS(ADC_BITS)
  ) i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .start               (start),
    .busy                (busy),
    .adc_sample_i        (adc_sample),
    .done_o              (done),
    .pressure_millibar_o (pressure_millibar),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  adc_pressure_checker #(
    .ADC_BITS(ADC_BITS)
  ) i_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .start_i             (start),
    .busy_i              (busy),
    .adc_sample_i        (adc_sample),
    .done_i              (done),
    .pressure_millibar_i (pressure_millibar),
    .psel_i              (psel),
    .penable_i           (penable),
    .pwrite_i            (pwrite),
    .paddr_i             (paddr),
    .pwdata_i            (pwdata),
    .prdata_i            (prdata),
    .pready_i            (pready),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb_adc_to_pressure_scaler_unit failed");
    $finish;
  end

  task automatic send_sample(input logic [ADC_BITS-1:0] sample, input bit allow_idle);
    while (allow_idle && $urandom_range(99) < 36) begin
      @(negedge clk);
      start <= 1'b0;
      adc_sample <= ADC_BITS'($urandom);
    end
    @(negedge clk);
    start <= 1'b1;
    adc_sample <= sample;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_requests();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_access(input logic [REG_IDX_W-1:0] idx, input bit is_write,
                            input logic [APB_DW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits are filled with noise; the registers must drop them.
  task automatic set_scaling(input int unsigned fs_mv, input int unsigned offset_mv,
                             input int unsigned fs_mbar);
    int unsigned sat_mv;
    drain_requests();
    apb_access(REG_FS_MV, 1'b1, ($urandom & ~32'h1FFF) | fs_mv);
    apb_access(REG_OFFSET, 1'b1, ($urandom & ~32'h1FFF) | offset_mv);
    apb_access(REG_FS_MBAR, 1'b1, ($urandom & ~32'hFFFF) | fs_mbar);
    if ($urandom_range(2) == 0) apb_access(REG_UNUSED, 1'b1, $urandom);
    apb_access(REG_FS_MV, 1'b0, '0);
    apb_access(REG_OFFSET, 1'b0, '0);
    apb_access(REG_FS_MBAR, 1'b0, '0);
    sat_mv = fs_mv < FS_MV_MIN ? FS_MV_MIN : (fs_mv > FS_MV_MAX ? FS_MV_MAX : fs_mv);
    fs_mv_set  = sat_mv;
    offset_set = offset_mv;
    full_count = ADC_MAX * sat_mv / REF_MV;
    if (full_count == 0) full_count = 1;
  endtask

  function automatic logic [ADC_BITS-1:0] pick_sample();
    int unsigned knee;
    knee = offset_set * full_count / fs_mv_set;
    case ($urandom_range(9))
      0: return '0;
      1: return ADC_BITS'(ADC_MAX);
      2: return ADC_BITS'(full_count + $urandom_range(2) - 1);
      3: return ADC_BITS'(knee > ADC_MAX ? ADC_MAX : knee + $urandom_range(2) - 1);
      default: return ADC_BITS'($urandom);
    endcase
  endfunction

  initial begin
    logic [ADC_BITS-1:0] directed_reset[9];
    logic [ADC_BITS-1:0] directed_knee[7];
    int unsigned fs_mv;
    int unsigned offset_mv;
    int unsigned fs_mbar;
    start      = 1'b0;
    adc_sample = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rst_n      = 1'b0;
    fs_mv_set  = FS_MV_RST;
    offset_set = OFFSET_RST;
    full_count = ADC_MAX * FS_MV_RST / REF_MV;
    directed_reset = '{10'd0, 10'd1, 10'd2, 10'd511, 10'd512, 10'd1022, 10'd1023,
                       10'h155, 10'h2AA};
    directed_knee  = '{10'd203, 10'd204, 10'd205, 10'd1023, 10'd0, 10'd61, 10'd62};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings first, then a sample range that clamps and an offset that floors.
    foreach (directed_reset[i]) send_sample(directed_reset[i], 1'b1);
    set_scaling(1000, 300, 12345);
    foreach (directed_knee[i]) send_sample(directed_knee[i], 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin fs_mv = FS_MV_MIN; offset_mv = 0;    fs_mbar = 65535; end
        1: begin fs_mv = 8191;      offset_mv = 8191; fs_mbar = 0;     end
        2: begin fs_mv = FS_MV_MAX; offset_mv = 0;    fs_mbar = 65535; end
        3: begin fs_mv = 0;         offset_mv = 2;    fs_mbar = 65535; end
        default: begin
          case ($urandom_range(4))
            0: fs_mv = $urandom_range(4);
            1: fs_mv = $urandom_range(8191, 5001);
            default: fs_mv = $urandom_range(FS_MV_MAX, FS_MV_MIN);
          endcase
          case ($urandom_range(3))
            0: offset_mv = 0;
            1: offset_mv = $urandom_range(8191);
            default: offset_mv = $urandom_range(fs_mv > FS_MV_MAX ? FS_MV_MAX : fs_mv);
          endcase
          fs_mbar = $urandom_range(1) ? $urandom_range(65535) : 65535;
        end
      endcase
      set_scaling(fs_mv, offset_mv, fs_mbar);
      // Phase two runs back to back with no gaps.
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_sample(), p != 2);
    end

    drain_requests();
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_adc_to_pressure_scaler_unit passed");
    end else begin
      $display("tb_adc_to_pressure_scaler_unit failed");
    end
    $finish;
  end

endmodule
